### hw/rtl/assert_macros.svh
// Assertion helpers; clk and rst_n are taken from the scope of the user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define IEM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iem: assertion failed");

// Next-cycle implication.
`define IEM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iem: assertion failed");

`endif

### hw/rtl/iem_pkg.sv
package iem_pkg;

    localparam int DEF_MAX_MAPPINGS = 16;
    localparam int QUEUE_DEPTH      = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_TOGGLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd2;

    localparam logic [4:0] EV_SYNC = 5'd0;
    localparam logic [4:0] EV_KEY  = 5'd1;
    localparam logic [4:0] EV_REL  = 5'd2;

    localparam logic [9:0] KEY_CTRL = 10'd29;
    localparam logic [9:0] KEY_C    = 10'd46;
    localparam logic [9:0] KEY_V    = 10'd47;

    localparam logic [31:0] VAL_UP   = 32'd0;
    localparam logic [31:0] VAL_DOWN = 32'd1;

    localparam logic [10:0] TGT_COPY  = 11'h7FE;  // -2
    localparam logic [10:0] TGT_PASTE = 11'h7FD;  // -3

    localparam logic [1:0] LAYER_BASE  = 2'd0;
    localparam logic [1:0] LAYER_SHIFT = 2'd1;
    localparam logic [1:0] LAYER_NONE  = 2'd2;

    typedef enum logic [1:0] {
        F_IDLE,
        F_READ,
        F_CHECK,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_KEY,
        KIND_MACRO,
        KIND_TAP,
        KIND_PASS
    } kind_t;

    // Work handed from the classifier to the emitter.
    typedef struct packed {
        logic        hrel;     // release of the held key goes first
        logic [9:0]  hcode;
        kind_t       kind;
        logic        paste;    // macro letter: V when set, else C
        logic [4:0]  ev_type;
        logic [9:0]  code;
        logic [31:0] value;
    } job_t;

endpackage

### hw/rtl/iem_ifs.sv
interface iem_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic [4:0]         event_type;
    logic [9:0]         event_code;
    logic signed [31:0] event_value;
    logic [3:0]         entry_index;
    logic               entry_layer;
    logic [4:0]         entry_source_type;
    logic [9:0]         entry_source_code;
    logic signed [31:0] entry_source_value;
    logic signed [10:0] entry_target;

    modport source (
        output valid, command, event_type, event_code, event_value, entry_index,
               entry_layer, entry_source_type, entry_source_code,
               entry_source_value, entry_target,
        input  ready
    );
    modport sink (
        input  valid, command, event_type, event_code, event_value, entry_index,
               entry_layer, entry_source_type, entry_source_code,
               entry_source_value, entry_target,
        output ready
    );
endinterface

interface iem_out_if;
    logic               valid;
    logic               ready;
    logic [4:0]         out_type;
    logic [9:0]         out_code;
    logic signed [31:0] out_value;
    logic               last_of_run;

    modport source (
        output valid, out_type, out_code, out_value, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, out_type, out_code, out_value, last_of_run,
        output ready
    );
endinterface

interface iem_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_idx;
    logic [9:0]  data;

    modport source (
        output valid, reg_idx, data,
        input  ready
    );
    modport sink (
        input  valid, reg_idx, data,
        output ready
    );
endinterface

### hw/rtl/iem_front.sv
module iem_front
    import iem_pkg::*;
#(
    parameter int MAX_MAPPINGS = DEF_MAX_MAPPINGS
) (
    input  logic       clk,
    input  logic       rst_n,
    iem_in_if.sink     evt_in,
    iem_cfg_if.sink    cfg,
    output logic       q_push,
    output job_t       q_data,
    input  logic       q_full
);

    localparam int IDX_W = (MAX_MAPPINGS > 1) ? $clog2(MAX_MAPPINGS) : 1;
    localparam int CNT_W = $clog2(MAX_MAPPINGS + 1);

    typedef struct packed {
        logic        layer;
        logic [4:0]  src_type;
        logic [9:0]  src_code;
        logic [31:0] src_value;
        logic [10:0] target;
    } entry_t;

    front_state_t state_reg, state_next;

    logic [9:0]  toggle_reg;
    logic [9:0]  hold_reg;
    logic [4:0]  count_reg;

    logic [1:0]  layer_reg;
    logic        held_vld_reg;
    logic [9:0]  held_code_reg;

    logic [4:0]  ev_type_reg;
    logic [9:0]  ev_code_reg;
    logic [31:0] ev_value_reg;

    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] cnt_lim;

    logic        hrel_reg;
    logic [9:0]  hcode_reg;
    kind_t       kind_reg;
    logic        paste_reg;
    logic [9:0]  code_reg;

    entry_t                  mem [MAX_MAPPINGS];
    logic [MAX_MAPPINGS-1:0] vld_reg;
    entry_t                  rd_data_reg;
    logic                    rd_vld_reg;

    logic   acc;
    logic   tog_hit;
    logic   hold_hit;
    logic   rel_held;
    logic   wr_ok;
    logic   lay_ok;
    logic   key_hit;
    logic   rel_hit;
    logic   hit;
    kind_t  hit_kind;
    entry_t wr_entry;

    assign cfg.ready = 1'b1;

    assign acc      = evt_in.valid && evt_in.ready;
    assign tog_hit  = (evt_in.event_type == EV_KEY) && (evt_in.event_code == toggle_reg);
    assign hold_hit = (evt_in.event_type == EV_KEY) && (evt_in.event_code == hold_reg);
    // key release while a remapped key is held: release it first
    assign rel_held = !tog_hit && !hold_hit && (evt_in.event_type == EV_KEY)
                      && (evt_in.event_value == VAL_UP) && held_vld_reg;
    assign wr_ok    = 32'(evt_in.entry_index) < MAX_MAPPINGS;

    always_comb
    begin
        wr_entry.layer     = evt_in.entry_layer;
        wr_entry.src_type  = evt_in.entry_source_type;
        wr_entry.src_code  = evt_in.entry_source_code;
        wr_entry.src_value = evt_in.entry_source_value;
        wr_entry.target    = evt_in.entry_target;
    end

    always_comb
    begin
        if (32'(count_reg) > MAX_MAPPINGS)
            cnt_lim = CNT_W'(MAX_MAPPINGS);
        else
            cnt_lim = CNT_W'(count_reg);
    end

    // Entry compare, one entry per visit
    assign lay_ok  = rd_vld_reg && ({1'b0, rd_data_reg.layer} == layer_reg);
    assign key_hit = lay_ok && (ev_type_reg == EV_KEY) && (rd_data_reg.src_type == EV_KEY)
                     && (rd_data_reg.src_code == ev_code_reg);
    assign rel_hit = lay_ok && (ev_type_reg == EV_REL) && (rd_data_reg.src_type == EV_REL)
                     && (rd_data_reg.src_code == ev_code_reg)
                     && (rd_data_reg.src_value == ev_value_reg);
    assign hit     = key_hit || rel_hit;

    always_comb
    begin
        hit_kind = KIND_NONE;
        if (key_hit)
        begin
            if (!rd_data_reg.target[10])
                hit_kind = KIND_KEY;
            else if (ev_value_reg == VAL_DOWN && (rd_data_reg.target == TGT_COPY ||
                                                  rd_data_reg.target == TGT_PASTE))
                hit_kind = KIND_MACRO;
        end
        else if (rel_hit && !rd_data_reg.target[10])
            hit_kind = KIND_TAP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        evt_in.ready = 1'b0;
        q_push       = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                evt_in.ready = 1'b1;
                if (acc && !evt_in.command && !tog_hit && !hold_hit)
                    state_next = F_READ;
            end
            F_READ:
            begin
                if (idx_reg >= cnt_lim)
                    state_next = F_PUSH;
                else
                    state_next = F_CHECK;
            end
            F_CHECK:
            begin
                if (hit)
                    state_next = (hrel_reg || hit_kind != KIND_NONE) ? F_PUSH : F_IDLE;
                else
                    state_next = F_READ;
            end
            F_PUSH:
            begin
                q_push = !q_full;
                if (!q_full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        q_data.hrel    = hrel_reg;
        q_data.hcode   = hcode_reg;
        q_data.kind    = kind_reg;
        q_data.paste   = paste_reg;
        q_data.ev_type = ev_type_reg;
        q_data.code    = code_reg;
        q_data.value   = ev_value_reg;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            toggle_reg <= '0;
            hold_reg   <= '0;
            count_reg  <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.reg_idx)
                REG_TOGGLE: toggle_reg <= cfg.data;
                REG_HOLD:   hold_reg   <= cfg.data;
                REG_COUNT:  count_reg  <= cfg.data[4:0];
                default: ;
            endcase
        end
    end

    // Table storage; entries never written read as invalid
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && acc && evt_in.command && wr_ok)
            mem[IDX_W'(evt_in.entry_index)] <= wr_entry;
        if (state_reg == F_READ)
            rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == F_IDLE && acc && evt_in.command && wr_ok)
                vld_reg[IDX_W'(evt_in.entry_index)] <= 1'b1;
            if (state_reg == F_READ)
                rd_vld_reg <= vld_reg[idx_reg[IDX_W-1:0]];
        end
    end

    // Event latch
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && acc)
        begin
            ev_type_reg  <= evt_in.event_type;
            ev_code_reg  <= evt_in.event_code;
            ev_value_reg <= evt_in.event_value;
        end
        if (state_reg == F_READ && idx_reg >= cnt_lim)
            code_reg <= ev_code_reg;
        else if (state_reg == F_CHECK && hit)
            code_reg <= rd_data_reg.target[9:0];
    end

    // Layer, held key and search control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_reg     <= LAYER_BASE;
            held_vld_reg  <= 1'b0;
            held_code_reg <= '0;
            idx_reg       <= '0;
            hrel_reg      <= 1'b0;
            hcode_reg     <= '0;
            kind_reg      <= KIND_NONE;
            paste_reg     <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (acc && !evt_in.command)
                    begin
                        idx_reg  <= '0;
                        hrel_reg <= rel_held;
                        if (tog_hit)
                        begin
                            if (evt_in.event_value == VAL_DOWN)
                                layer_reg <= (layer_reg == LAYER_BASE) ? LAYER_SHIFT
                                                                       : LAYER_BASE;
                        end
                        else if (hold_hit)
                        begin
                            if (evt_in.event_value == VAL_UP)
                                layer_reg <= LAYER_BASE;
                            else if (evt_in.event_value == VAL_DOWN)
                                layer_reg <= LAYER_SHIFT;
                            else
                                layer_reg <= LAYER_NONE;
                        end
                        else if (rel_held)
                        begin
                            hcode_reg    <= held_code_reg;
                            held_vld_reg <= 1'b0;
                        end
                    end
                end
                F_READ:
                begin
                    if (idx_reg >= cnt_lim)
                        kind_reg <= hrel_reg ? KIND_NONE : KIND_PASS;
                end
                F_CHECK:
                begin
                    if (hit)
                    begin
                        kind_reg  <= hit_kind;
                        paste_reg <= (rd_data_reg.target == TGT_PASTE);
                        if (key_hit && !rd_data_reg.target[10])
                        begin
                            if (ev_value_reg == VAL_DOWN)
                            begin
                                held_vld_reg  <= 1'b1;
                                held_code_reg <= rd_data_reg.target[9:0];
                            end
                            else if (ev_value_reg == VAL_UP)
                                held_vld_reg <= 1'b0;
                        end
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                F_PUSH: ;
                default: ;
            endcase
        end
    end

endmodule

### hw/rtl/iem_queue.sv
module iem_queue
    import iem_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output job_t pop_data,
    output logic empty
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    job_t          slots [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign full     = (cnt_reg == CW'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = slots[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            slots[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop && !empty)
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if ((push && !full) && !(pop && !empty))
                cnt_reg <= cnt_reg + 1'b1;
            else if (!(push && !full) && (pop && !empty))
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

### hw/rtl/iem_back.sv
`include "assert_macros.svh"

module iem_back
    import iem_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  job_t       q_data,
    output logic       q_pop,
    iem_out_if.source  evt_out
);

    logic        busy_reg;
    job_t        job_reg;
    logic        hr_left_reg;
    logic [2:0]  step_reg;

    logic        out_valid_reg;
    logic [4:0]  out_type_reg;
    logic [9:0]  out_code_reg;
    logic [31:0] out_value_reg;
    logic        last_reg;

    logic [2:0]  body_len;
    logic [4:0]  cur_type;
    logic [9:0]  cur_code;
    logic [31:0] cur_value;
    logic        cur_last;
    logic [9:0]  letter;
    logic        adv;

    assign evt_out.valid       = out_valid_reg;
    assign evt_out.out_type    = out_type_reg;
    assign evt_out.out_code    = out_code_reg;
    assign evt_out.out_value   = out_value_reg;
    assign evt_out.last_of_run = last_reg;

    assign q_pop  = !busy_reg && !q_empty;
    assign adv    = busy_reg && (!out_valid_reg || evt_out.ready);
    assign letter = job_reg.paste ? KEY_V : KEY_C;

    always_comb
    begin
        case (job_reg.kind)
            KIND_KEY:   body_len = 3'd2;
            KIND_MACRO: body_len = 3'd6;
            KIND_TAP:   body_len = 3'd4;
            KIND_PASS:  body_len = 3'd1;
            default:    body_len = 3'd0;
        endcase
    end

    // Current event of the running sequence; sync is all zero
    always_comb
    begin
        cur_type  = EV_SYNC;
        cur_code  = '0;
        cur_value = '0;
        if (hr_left_reg)
        begin
            cur_last = (step_reg == 3'd1) && (body_len == 3'd0);
            if (step_reg == 3'd0)
            begin
                cur_type = EV_KEY;
                cur_code = job_reg.hcode;
            end
        end
        else
        begin
            cur_last = (step_reg == body_len - 3'd1);
            case (job_reg.kind)
                KIND_KEY:
                begin
                    if (step_reg == 3'd0)
                    begin
                        cur_type  = EV_KEY;
                        cur_code  = job_reg.code;
                        cur_value = job_reg.value;
                    end
                end
                KIND_MACRO:
                begin
                    case (step_reg)
                        3'd0:
                        begin
                            cur_type  = EV_KEY;
                            cur_code  = KEY_CTRL;
                            cur_value = VAL_DOWN;
                        end
                        3'd1:
                        begin
                            cur_type  = EV_KEY;
                            cur_code  = letter;
                            cur_value = VAL_DOWN;
                        end
                        3'd3:
                        begin
                            cur_type  = EV_KEY;
                            cur_code  = letter;
                        end
                        3'd4:
                        begin
                            cur_type  = EV_KEY;
                            cur_code  = KEY_CTRL;
                        end
                        default: ;
                    endcase
                end
                KIND_TAP:
                begin
                    if (step_reg == 3'd0 || step_reg == 3'd2)
                    begin
                        cur_type  = EV_KEY;
                        cur_code  = job_reg.code;
                        cur_value = (step_reg == 3'd0) ? VAL_DOWN : VAL_UP;
                    end
                end
                KIND_PASS:
                begin
                    cur_type  = job_reg.ev_type;
                    cur_code  = job_reg.code;
                    cur_value = job_reg.value;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= q_data;
        if (adv)
        begin
            out_type_reg  <= cur_type;
            out_code_reg  <= cur_code;
            out_value_reg <= cur_value;
            last_reg      <= cur_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            hr_left_reg   <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                out_valid_reg <= 1'b1;
            else if (evt_out.ready)
                out_valid_reg <= 1'b0;

            if (q_pop)
            begin
                busy_reg    <= 1'b1;
                hr_left_reg <= q_data.hrel;
                step_reg    <= '0;
            end
            else if (adv)
            begin
                if (cur_last)
                begin
                    busy_reg    <= 1'b0;
                    hr_left_reg <= 1'b0;
                    step_reg    <= '0;
                end
                else if (hr_left_reg && step_reg == 3'd1)
                begin
                    hr_left_reg <= 1'b0;
                    step_reg    <= '0;
                end
                else
                    step_reg <= step_reg + 3'd1;
            end
        end
    end

    // A job with nothing to emit would send spurious sync results
    `IEM_ASSERT_IMP(a_job_not_empty, q_pop, q_data.hrel || q_data.kind != KIND_NONE)
    `IEM_ASSERT_IMP(a_idle_clean, !busy_reg, step_reg == 3'd0 && !hr_left_reg)
    `IEM_ASSERT_NXT(a_last_ends_job, adv && cur_last, !busy_reg && out_valid_reg && last_reg)
    `IEM_ASSERT_IMP(a_step_in_range, busy_reg && !hr_left_reg, step_reg < body_len)

endmodule

### hw/rtl/input_event_remapper.sv
// Input event remapper. Items on evt_in either write one mapping slot
// (command 1) or carry an input event; results leave on evt_out, one per
// cycle within a run while evt_out is ready, with last_of_run on the final
// result of each event. A write or a layer button event is handled as it is
// accepted. Any other event is classified by visiting table entries in
// order, at most min(mapping_count, MAX_MAPPINGS) of them, each with one
// table read and one compare. A two-deep job queue sits between the
// classifier and the emitter, so the next event is classified while the
// results of earlier ones are still being sent; the emitter sends up to six
// results per event. Table slots that were never written since reset never
// match; no clearing pass is needed. cfg is always ready; registers may only
// be written while no event is in flight.
module input_event_remapper
    import iem_pkg::*;
#(
    parameter int MAX_MAPPINGS = DEF_MAX_MAPPINGS
) (
    input  logic       clk,
    input  logic       rst_n,
    iem_in_if.sink     evt_in,
    iem_out_if.source  evt_out,
    iem_cfg_if.sink    cfg
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    job_t q_in;
    job_t q_out;

    iem_front #(
        .MAX_MAPPINGS (MAX_MAPPINGS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .evt_in (evt_in),
        .cfg    (cfg),
        .q_push (q_push),
        .q_data (q_in),
        .q_full (q_full)
    );

    iem_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    iem_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .evt_out (evt_out)
    );

endmodule

### dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import iem_pkg::*;

    localparam logic        CMD_EVENT  = 1'b0;
    localparam logic        CMD_WRITE  = 1'b1;
    localparam logic [1:0]  REG_SPARE  = 2'd3;
    localparam logic [31:0] VAL_REPEAT = 32'd2;
    localparam logic [10:0] TGT_NONE   = 11'h7FF;  // -1: nothing held, or unknown target
    localparam int          SLOTS      = DEF_MAX_MAPPINGS;
    localparam int          SETTLE     = 80;
    localparam int          LONG_HOLD  = 400;

    typedef struct {
        logic        command;
        logic [4:0]  event_type;
        logic [9:0]  event_code;
        logic [31:0] event_value;
        logic [3:0]  entry_index;
        logic        entry_layer;
        logic [4:0]  entry_source_type;
        logic [9:0]  entry_source_code;
        logic [31:0] entry_source_value;
        logic [10:0] entry_target;
    } evt_item_t;

    typedef struct {
        logic [4:0]  typ;
        logic [9:0]  code;
        logic [31:0] value;
        logic        last;
    } out_event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    iem_in_if  evt_in ();
    iem_out_if evt_out ();
    iem_cfg_if cfg ();

    input_event_remapper uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt_in  (evt_in),
        .evt_out (evt_out),
        .cfg     (cfg)
    );

    always #5ns clk = ~clk;

    // remapper state as the testbench sees it
    logic [9:0]  toggle_code;
    logic [9:0]  hold_code;
    logic [4:0]  map_count;
    logic [1:0]  layer;
    logic [10:0] held;
    logic        tbl_layer [SLOTS];
    logic [4:0]  tbl_src_type [SLOTS];
    logic [9:0]  tbl_src_code [SLOTS];
    logic [31:0] tbl_src_value [SLOTS];
    logic [10:0] tbl_target [SLOTS];

    evt_item_t  events_to_send [$];
    out_event_t out_events_due [$];
    evt_item_t  cur_item;

    int mismatch_cnt = 0;
    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    int send_wait = 0;
    int recv_wait = 0;
    bit send_busy = 1'b0;
    bit recv_busy = 1'b1;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    function automatic int draw_wait(inout bit busy);
        if ($urandom_range(0, 15) == 0)
            busy = !busy;
        return busy ? $urandom_range(0, 7) : 0;
    endfunction

    function automatic out_event_t mk_out(input logic [4:0] t, input logic [9:0] c,
                                          input logic [31:0] v);
        out_event_t e;
        e.typ   = t;
        e.code  = c;
        e.value = v;
        e.last  = 1'b0;
        return e;
    endfunction

    function automatic void remap_event(input evt_item_t it);
        out_event_t run [$];
        logic [9:0] letter;
        logic [3:0] s;
        bit taken;
        int lim;
        int i;
        taken = 1'b0;
        if (it.command == CMD_WRITE) begin
            tbl_layer[it.entry_index]     = it.entry_layer;
            tbl_src_type[it.entry_index]  = it.entry_source_type;
            tbl_src_code[it.entry_index]  = it.entry_source_code;
            tbl_src_value[it.entry_index] = it.entry_source_value;
            tbl_target[it.entry_index]    = it.entry_target;
            return;
        end
        // toggle wins over hold when both codes are equal
        if (it.event_type == EV_KEY && it.event_code == toggle_code) begin
            if (it.event_value == VAL_DOWN)
                layer = (layer == LAYER_BASE) ? LAYER_SHIFT : LAYER_BASE;
            return;
        end
        if (it.event_type == EV_KEY && it.event_code == hold_code) begin
            layer = (it.event_value == VAL_UP)   ? LAYER_BASE :
                    (it.event_value == VAL_DOWN) ? LAYER_SHIFT : LAYER_NONE;
            return;
        end
        if (it.event_type == EV_KEY && it.event_value == VAL_UP && held != TGT_NONE) begin
            run.push_back(mk_out(EV_KEY, held[9:0], VAL_UP));
            run.push_back(mk_out(EV_SYNC, 10'd0, 32'd0));
            held  = TGT_NONE;
            taken = 1'b1;
        end
        lim = (map_count > SLOTS) ? SLOTS : map_count;
        for (i = 0; i < lim; i++) begin
            s = 4'(i);
            if ({1'b0, tbl_layer[s]} != layer)
                continue;
            if (it.event_type == EV_KEY && tbl_src_type[s] == EV_KEY &&
                it.event_code == tbl_src_code[s]) begin
                if (!tbl_target[s][10]) begin
                    if (it.event_value == VAL_DOWN)
                        held = tbl_target[s];
                    else if (it.event_value == VAL_UP)
                        held = TGT_NONE;
                    run.push_back(mk_out(EV_KEY, tbl_target[s][9:0], it.event_value));
                    run.push_back(mk_out(EV_SYNC, 10'd0, 32'd0));
                end else if (it.event_value == VAL_DOWN &&
                             (tbl_target[s] == TGT_COPY || tbl_target[s] == TGT_PASTE)) begin
                    letter = (tbl_target[s] == TGT_COPY) ? KEY_C : KEY_V;
                    run.push_back(mk_out(EV_KEY, KEY_CTRL, VAL_DOWN));
                    run.push_back(mk_out(EV_KEY, letter, VAL_DOWN));
                    run.push_back(mk_out(EV_SYNC, 10'd0, 32'd0));
                    run.push_back(mk_out(EV_KEY, letter, VAL_UP));
                    run.push_back(mk_out(EV_KEY, KEY_CTRL, VAL_UP));
                    run.push_back(mk_out(EV_SYNC, 10'd0, 32'd0));
                end
                taken = 1'b1;
                break;
            end
            if (it.event_type == EV_REL && tbl_src_type[s] == EV_REL &&
                it.event_code == tbl_src_code[s] && it.event_value == tbl_src_value[s]) begin
                if (!tbl_target[s][10]) begin
                    run.push_back(mk_out(EV_KEY, tbl_target[s][9:0], VAL_DOWN));
                    run.push_back(mk_out(EV_SYNC, 10'd0, 32'd0));
                    run.push_back(mk_out(EV_KEY, tbl_target[s][9:0], VAL_UP));
                    run.push_back(mk_out(EV_SYNC, 10'd0, 32'd0));
                end
                taken = 1'b1;
                break;
            end
        end
        if (!taken)
            run.push_back(mk_out(it.event_type, it.event_code, it.event_value));
        if (run.size() != 0)
            run[run.size() - 1].last = 1'b1;
        foreach (run[k])
            out_events_due.push_back(run[k]);
    endfunction

    // every field random; callers overwrite the ones that matter
    function automatic evt_item_t rand_item();
        evt_item_t it;
        it.command            = 1'($urandom_range(0, 1));
        it.event_type         = 5'($urandom_range(0, 31));
        it.event_code         = 10'($urandom_range(0, 767));
        it.event_value        = $urandom;
        it.entry_index        = 4'($urandom_range(0, 15));
        it.entry_layer        = 1'($urandom_range(0, 1));
        it.entry_source_type  = 5'($urandom_range(0, 31));
        it.entry_source_code  = 10'($urandom_range(0, 767));
        it.entry_source_value = $urandom;
        it.entry_target       = 11'($urandom_range(0, 770) - 3);
        return it;
    endfunction

    function automatic void add_entry(input logic [3:0] idx, input logic lyr,
                                      input logic [4:0] st, input logic [9:0] sc,
                                      input logic [31:0] sv, input logic [10:0] tgt);
        evt_item_t it;
        it = rand_item();
        it.command            = CMD_WRITE;
        it.entry_index        = idx;
        it.entry_layer        = lyr;
        it.entry_source_type  = st;
        it.entry_source_code  = sc;
        it.entry_source_value = sv;
        it.entry_target       = tgt;
        events_to_send.push_back(it);
    endfunction

    function automatic void add_event(input logic [4:0] t, input logic [9:0] c,
                                      input logic [31:0] v);
        evt_item_t it;
        it = rand_item();
        it.command     = CMD_EVENT;
        it.event_type  = t;
        it.event_code  = c;
        it.event_value = v;
        events_to_send.push_back(it);
    endfunction

    // codes come from a small pool so table hits and button presses are common
    function automatic void plan_random_phase(input int n);
        logic [9:0]  codes [8];
        logic [31:0] amounts [4];
        logic [9:0]  c;
        logic [4:0]  st;
        logic [10:0] tgt;
        logic [31:0] v;
        int k;
        int roll;
        codes[0] = toggle_code;
        codes[1] = hold_code;
        for (k = 2; k < 8; k++)
            codes[3'(k)] = 10'($urandom_range(0, 767));
        amounts[0] = 32'hFFFF_FFFF;
        amounts[1] = 32'd1;
        amounts[2] = $urandom;
        amounts[3] = $urandom_range(0, 15);
        k = 0;
        while (k < n) begin
            roll = (k < 4) ? 0 : $urandom_range(0, 99);
            c = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 767))
                                            : codes[3'($urandom_range(0, 7))];
            if (roll < 15) begin
                roll = $urandom_range(0, 99);
                st = (roll < 45) ? EV_KEY : (roll < 90) ? EV_REL : 5'($urandom_range(0, 31));
                roll = $urandom_range(0, 99);
                tgt = (roll < 10) ? TGT_COPY : (roll < 20) ? TGT_PASTE :
                      (roll < 27) ? TGT_NONE : 11'($urandom_range(0, 767));
                add_entry(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), st,
                          codes[3'($urandom_range(2, 7))], amounts[2'($urandom_range(0, 3))],
                          tgt);
                k++;
            end else if (roll < 45) begin
                add_event(EV_KEY, c, VAL_DOWN);
                if ($urandom_range(0, 2) == 0) begin
                    add_event(EV_KEY, c, VAL_REPEAT);
                    k++;
                end
                add_event(EV_KEY, c, VAL_UP);
                k += 2;
            end else if (roll < 60) begin
                v = ($urandom_range(0, 3) == 0) ? $urandom : amounts[2'($urandom_range(0, 3))];
                add_event(EV_REL, c, v);
                k++;
            end else if (roll < 82) begin
                v = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 2);
                add_event(EV_KEY, c, v);
                k++;
            end else begin
                add_event(5'($urandom_range(0, 31)), 10'($urandom_range(0, 767)), $urandom);
                k++;
            end
        end
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        @(negedge clk);
        cfg.valid   <= 1'b1;
        cfg.reg_idx <= idx;
        cfg.data    <= val;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            REG_TOGGLE: toggle_code = val;
            REG_HOLD:   hold_code = val;
            REG_COUNT:  map_count = val[4:0];
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic set_config(input logic [9:0] tog, input logic [9:0] hld,
                              input logic [4:0] cnt);
        write_reg(REG_TOGGLE, tog);
        write_reg(REG_HOLD, hld);
        write_reg(REG_COUNT, {5'd0, cnt});
    endtask

    // drain, then give the classifier time to finish items that emit nothing
    task automatic wait_idle();
        while (events_to_send.size() != 0 || evt_in.valid || out_events_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // input side
    always @(posedge clk) begin
        in_taken = rst_n && evt_in.valid && evt_in.ready;
        if (in_taken)
            remap_event(cur_item);
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            evt_in.valid <= 1'b0;
        end else if (!evt_in.valid || in_taken) begin
            if (send_wait != 0) begin
                send_wait--;
                evt_in.valid <= 1'b0;
            end else if (events_to_send.size() != 0) begin
                cur_item = events_to_send.pop_front();
                evt_in.command            <= cur_item.command;
                evt_in.event_type         <= cur_item.event_type;
                evt_in.event_code         <= cur_item.event_code;
                evt_in.event_value        <= cur_item.event_value;
                evt_in.entry_index        <= cur_item.entry_index;
                evt_in.entry_layer        <= cur_item.entry_layer;
                evt_in.entry_source_type  <= cur_item.entry_source_type;
                evt_in.entry_source_code  <= cur_item.entry_source_code;
                evt_in.entry_source_value <= cur_item.entry_source_value;
                evt_in.entry_target       <= cur_item.entry_target;
                evt_in.valid              <= 1'b1;
                send_wait = draw_wait(send_busy);
            end else begin
                evt_in.valid <= 1'b0;
            end
        end
    end

    // output side
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left--;
        end else if (hold_req && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
    end

    always @(posedge clk) begin
        out_event_t want;
        out_taken = rst_n && evt_out.valid && evt_out.ready;
        if (out_taken) begin
            if (out_events_due.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: type %0d code %0d value %0d last %0b",
                             evt_out.out_type, evt_out.out_code, $signed(evt_out.out_value),
                             evt_out.last_of_run);
            end else begin
                want = out_events_due.pop_front();
                if (evt_out.out_type !== want.typ || evt_out.out_code !== want.code ||
                    evt_out.out_value !== want.value || evt_out.last_of_run !== want.last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("bad result: want %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                 want.typ, want.code, $signed(want.value), want.last,
                                 evt_out.out_type, evt_out.out_code,
                                 $signed(evt_out.out_value), evt_out.last_of_run);
                end
            end
        end
    end

    always @(negedge clk) begin
        if (out_taken)
            recv_wait = draw_wait(recv_busy);
        if (!rst_n || hold_left != 0 || recv_wait != 0) begin
            evt_out.ready <= 1'b0;
            if (rst_n && hold_left == 0 && recv_wait != 0)
                recv_wait--;
        end else begin
            evt_out.ready <= 1'b1;
        end
    end

    initial begin
        #2ms;
        $display("input_event_remapper: mismatch");
        $finish;
    end

    initial begin
        int p;
        logic [9:0] c;
        evt_in.valid              = 1'b0;
        evt_in.command            = CMD_EVENT;
        evt_in.event_type         = EV_SYNC;
        evt_in.event_code         = '0;
        evt_in.event_value        = '0;
        evt_in.entry_index        = '0;
        evt_in.entry_layer        = 1'b0;
        evt_in.entry_source_type  = '0;
        evt_in.entry_source_code  = '0;
        evt_in.entry_source_value = '0;
        evt_in.entry_target       = '0;
        evt_out.ready             = 1'b0;
        cfg.valid                 = 1'b0;
        cfg.reg_idx               = REG_TOGGLE;
        cfg.data                  = '0;
        toggle_code = '0;
        hold_code   = '0;
        map_count   = '0;
        layer       = LAYER_BASE;
        held        = TGT_NONE;
        for (p = 0; p < SLOTS; p++) begin
            tbl_layer[4'(p)]     = 1'b0;
            tbl_src_type[4'(p)]  = '0;
            tbl_src_code[4'(p)]  = '0;
            tbl_src_value[4'(p)] = '0;
            tbl_target[4'(p)]    = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_config(10'd100, 10'd101, 5'd16);
        add_entry(4'd0, 1'b0, EV_KEY, 10'd30, 32'd0, 11'd767);
        add_entry(4'd1, 1'b0, EV_KEY, 10'd31, 32'd0, TGT_COPY);
        add_entry(4'd2, 1'b0, EV_KEY, 10'd32, 32'd0, TGT_PASTE);
        add_entry(4'd3, 1'b0, EV_KEY, 10'd33, 32'd0, TGT_NONE);
        add_entry(4'd4, 1'b0, EV_REL, 10'd8, 32'hFFFF_FFFF, 11'd103);
        add_entry(4'd5, 1'b0, EV_REL, 10'd8, 32'd1, TGT_COPY);
        add_entry(4'd6, 1'b1, EV_KEY, 10'd30, 32'd0, 11'd0);
        add_entry(4'd15, 1'b1, EV_REL, 10'd767, 32'h7FFF_FFFF, 11'd5);
        add_event(EV_SYNC, 10'd0, 32'd0);
        add_event(EV_KEY, 10'd30, VAL_DOWN);
        add_event(EV_KEY, 10'd50, VAL_UP);          // releases the held key only
        add_event(EV_KEY, 10'd31, VAL_DOWN);        // copy macro
        add_event(EV_KEY, 10'd31, VAL_UP);          // macro key up: swallowed
        add_event(EV_KEY, 10'd32, VAL_DOWN);        // paste macro
        add_event(EV_KEY, 10'd33, VAL_DOWN);        // unknown negative target
        add_event(EV_REL, 10'd8, 32'hFFFF_FFFF);    // scroll tap
        add_event(EV_REL, 10'd8, 32'd1);            // scroll with negative target
        add_event(EV_REL, 10'd8, 32'd5);
        add_event(EV_KEY, 10'd100, VAL_DOWN);       // toggle to shifted layer
        add_event(EV_KEY, 10'd30, VAL_DOWN);
        add_event(EV_KEY, 10'd30, VAL_UP);          // held release plus mapped release
        add_event(EV_REL, 10'd767, 32'h7FFF_FFFF);  // last slot
        add_event(EV_KEY, 10'd101, VAL_REPEAT);     // hold button: no layer matches
        add_event(EV_KEY, 10'd30, VAL_DOWN);
        add_event(EV_KEY, 10'd101, VAL_UP);
        add_event(5'd31, 10'd767, 32'h8000_0000);
        wait_idle();

        // same code on both buttons: toggle takes it
        set_config(10'd0, 10'd0, 5'd16);
        write_reg(REG_SPARE, 10'h3FF);
        add_event(EV_KEY, 10'd0, VAL_DOWN);
        add_event(EV_KEY, 10'd0, VAL_UP);
        wait_idle();

        for (p = 0; p < 6; p++) begin
            case (p)
                0: set_config(10'd767, 10'd0, 5'd16);
                1: set_config(10'($urandom_range(0, 767)), 10'($urandom_range(0, 767)), 5'd0);
                2: begin
                    c = 10'($urandom_range(0, 767));
                    set_config(c, c, 5'd16);
                end
                3: begin
                    set_config(10'($urandom_range(0, 767)), 10'($urandom_range(0, 767)),
                               5'd16);
                    hold_req = 1'b1;
                end
                4: set_config(10'($urandom_range(0, 767)), 10'($urandom_range(0, 767)), 5'd1);
                default: set_config(10'($urandom_range(0, 767)), 10'($urandom_range(0, 767)),
                                    5'($urandom_range(0, 16)));
            endcase
            plan_random_phase(31);
            wait_idle();
        end

        if (mismatch_cnt == 0)
            $display("input_event_remapper: match");
        else
            $display("input_event_remapper: mismatch");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/iem_pkg.sv
hw/rtl/iem_ifs.sv
hw/rtl/iem_front.sv
hw/rtl/iem_queue.sv
hw/rtl/iem_back.sv
hw/rtl/input_event_remapper.sv
dv/testbench.sv
